// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// assertion checked out of reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// assertion checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== design/qpudc_pkg.sv =====
// ---------------------------------------------------------------------------
// qpudc_pkg
// Shared types and constants of the qualified pulse up/down counter.
// ---------------------------------------------------------------------------
package qpudc_pkg;

	localparam int NUM_PORTS   = 2;
	localparam int PORT_W      = 1;
	localparam int TIME_W      = 32;
	localparam int CNT_W       = 32;
	localparam int MIN_W       = 16;

	localparam logic [MIN_W-1:0] MIN_PULSE_RESET = 16'd200;
	localparam logic [CNT_W-1:0] COUNT_MAX       = 32'hFFFF_FFFF;

	// one edge event
	typedef struct packed {
		logic [PORT_W-1:0] port;
		logic              level;
		logic              down;
		logic [TIME_W-1:0] time_ms;
	} event_t;

	// per-port state
	typedef struct packed {
		logic              armed;
		logic [TIME_W-1:0] start_time;
		logic [CNT_W-1:0]  count;
	} port_state_t;

	// result of evaluating one event
	typedef struct packed {
		logic              has_result;
		logic [TIME_W-1:0] width;
		logic              counted;
	} eval_res_t;

endpackage

// ===== design/qpudc_port_regs.sv =====
// ---------------------------------------------------------------------------
// qpudc_port_regs
// Per-port armed flag, start time and counter; one read and one write port.
// ---------------------------------------------------------------------------
module qpudc_port_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [qpudc_pkg::PORT_W-1:0]    rd_port,
	output qpudc_pkg::port_state_t          rd_state,
	input  logic                            wr_en,
	input  logic [qpudc_pkg::PORT_W-1:0]    wr_port,
	input  qpudc_pkg::port_state_t          wr_state
);

	qpudc_pkg::port_state_t state_q [qpudc_pkg::NUM_PORTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < qpudc_pkg::NUM_PORTS; i++) begin
				state_q[i] <= '0;
			end
		end else if (wr_en) begin
			state_q[wr_port] <= wr_state;
		end
	end

	assign rd_state = state_q[rd_port];

endmodule

// ===== design/qpudc_eval.sv =====
// ---------------------------------------------------------------------------
// qpudc_eval
// Event evaluation: arm on high, measure and count on low.
// ---------------------------------------------------------------------------
module qpudc_eval (
	input  qpudc_pkg::event_t               ev,
	input  qpudc_pkg::port_state_t          cur,
	input  logic [qpudc_pkg::MIN_W-1:0]     min_pulse,
	output qpudc_pkg::port_state_t          nxt,
	output qpudc_pkg::eval_res_t            res
);

	logic                            in_range;
	logic [qpudc_pkg::TIME_W-1:0]    width;
	logic                            long_enough;

	assign in_range    = 32'(ev.port) < 32'(qpudc_pkg::NUM_PORTS);
	assign width       = ev.time_ms - cur.start_time;   // modular
	assign long_enough = width > qpudc_pkg::TIME_W'(min_pulse);

	always_comb begin
		nxt            = cur;
		res.has_result = 1'b0;
		res.width      = width;
		res.counted    = 1'b0;
		if (in_range) begin
			if (ev.level) begin
				nxt.start_time = ev.time_ms;
				nxt.armed      = 1'b1;
			end else if (cur.armed) begin
				nxt.armed      = 1'b0;
				res.has_result = 1'b1;
				if (long_enough) begin
					if (!ev.down && (cur.count != qpudc_pkg::COUNT_MAX)) begin
						nxt.count   = cur.count + qpudc_pkg::CNT_W'(1);
						res.counted = 1'b1;
					end else if (ev.down && (cur.count != '0)) begin
						nxt.count   = cur.count - qpudc_pkg::CNT_W'(1);
						res.counted = 1'b1;
					end
				end
			end
		end
	end

endmodule

// ===== design/qualified_pulse_up_down_counter_unit.sv =====
// ---------------------------------------------------------------------------
// qualified_pulse_up_down_counter_unit
// Pulse-width qualified up/down counter for meter pulse inputs.
// ---------------------------------------------------------------------------
// Each input beat is one edge event on a pulse input. A high level stores the
// timestamp and arms the port (a second high just restarts the timing). A low
// level on an armed port disarms it and emits one output beat with the width
// (time_ms minus start, modulo 2^32), the counter after the pulse, and a
// counted flag. The counter moves only when the width strictly exceeds
// min_pulse_ms: up when direction_level is 0, down when 1, saturating at 0
// and 0xFFFFFFFF (a blocked step reports counted = 0). Low edges on an unarmed
// port and all high edges produce no output beat. Timing: one beat per clock
// sustained while the result channel is not stalled; an event waits in the
// input register, where the port state is read and updated, and its result
// then moves to the output register. Back-to-back events on the same
// port see the state left by the previous one. The output register frees
// the input stage as soon as it is taken, so a pending result does not block
// events that produce none. min_pulse_ms resets to 200 and should only be
// written while no event is in flight.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qualified_pulse_up_down_counter_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_wr_en,
	input  logic [qpudc_pkg::MIN_W-1:0]    cfg_wr_data,
	// event channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [qpudc_pkg::PORT_W-1:0]   port_index,
	input  logic                           pulse_level,
	input  logic                           direction_level,
	input  logic [qpudc_pkg::TIME_W-1:0]   time_ms,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [qpudc_pkg::PORT_W-1:0]   out_port,
	output logic [qpudc_pkg::TIME_W-1:0]   pulse_width_ms,
	output logic                           counted,
	output logic [qpudc_pkg::CNT_W-1:0]    count_value
);

	logic [qpudc_pkg::MIN_W-1:0]  min_pulse_q;

	// input stage
	logic                         valid_s1;
	qpudc_pkg::event_t            ev_s1;

	// output register
	logic                         out_valid_q;
	logic [qpudc_pkg::PORT_W-1:0] out_port_q;
	logic [qpudc_pkg::TIME_W-1:0] width_q;
	logic                         counted_q;
	logic [qpudc_pkg::CNT_W-1:0]  count_q;

	qpudc_pkg::port_state_t       cur_state;
	qpudc_pkg::port_state_t       nxt_state;
	qpudc_pkg::eval_res_t         res;

	logic out_free;
	logic advance;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q <= qpudc_pkg::MIN_PULSE_RESET;
		end else if (cfg_wr_en) begin
			min_pulse_q <= cfg_wr_data;
		end
	end

	// s1 retires when its result (if any) has a place to go
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!res.has_result || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ev_s1.port    <= port_index;
			ev_s1.level   <= pulse_level;
			ev_s1.down    <= direction_level;
			ev_s1.time_ms <= time_ms;
		end
	end

	qpudc_port_regs u_port_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_port  (ev_s1.port),
		.rd_state (cur_state),
		.wr_en    (advance),
		.wr_port  (ev_s1.port),
		.wr_state (nxt_state)
	);

	qpudc_eval u_eval (
		.ev        (ev_s1),
		.cur       (cur_state),
		.min_pulse (min_pulse_q),
		.nxt       (nxt_state),
		.res       (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res.has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && res.has_result) begin
			out_port_q <= ev_s1.port;
			width_q    <= res.width;
			counted_q  <= res.counted;
			count_q    <= nxt_state.count;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_port       = out_port_q;
	assign pulse_width_ms = width_q;
	assign counted        = counted_q;
	assign count_value    = count_q;

	// checks
	`ASSERT_ALWAYS(a_empty_s1_ready, clk, (!valid_s1 |-> in_ready), "empty stage not ready")
	`ASSERT_RST(a_result_lands, clk, arst_n, ((advance && res.has_result) |=> out_valid), "result lost")
	`ASSERT_RST(a_counted_width, clk, arst_n, ((out_valid && counted) |-> (pulse_width_ms > qpudc_pkg::TIME_W'(min_pulse_q))), "counted short pulse")
	`ASSERT_RST(a_stall_holds_s1, clk, arst_n, ((valid_s1 && !advance) |=> valid_s1), "stalled event dropped")

endmodule

// ===== tb/sv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for qualified_pulse_up_down_counter_unit. Edge events
// go in on the event channel and completed-pulse beats are checked against
// an in-bench tally of per-port start times, arm flags and counters. A short
// directed run covers the corner cases. Random phases at several
// min_pulse_ms settings follow, with random idling on both channels.
// ---------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import qpudc_pkg::*;

	localparam logic LEVEL_LOW  = 1'b0;
	localparam logic LEVEL_HIGH = 1'b1;
	localparam logic DIR_UP     = 1'b0;
	localparam logic DIR_DOWN   = 1'b1;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int DRAIN_CYCLES  = 6;     // lets events that produce no beat retire
	localparam int PHASE_BEATS   = 325;
	localparam int NUM_PHASES    = 6;
	localparam int IDLE_PERCENT  = 15;

	// one completed pulse as seen on the result channel
	typedef struct {
		logic [PORT_W-1:0] port;
		logic [TIME_W-1:0] width;
		logic              counted;
		logic [CNT_W-1:0]  count;
	} pulse_result_t;

	// Tracks per-port timing and counters, queues the result each accepted
	// event should produce, and checks output beats in order.
	class pulse_tally;
		logic [MIN_W-1:0]  min_pulse;
		logic [TIME_W-1:0] start_time [NUM_PORTS];
		bit                armed      [NUM_PORTS];
		logic [CNT_W-1:0]  tally      [NUM_PORTS];
		pulse_result_t     pending_pulses [$];
		int                errors;

		function new();
			min_pulse = MIN_PULSE_RESET;
			errors = 0;
			for (int p = 0; p < NUM_PORTS; p++) begin
				start_time[p] = '0;
				armed[p] = 1'b0;
				tally[p] = '0;
			end
		endfunction

		function void set_min(input logic [MIN_W-1:0] v);
			min_pulse = v;
		endfunction

		function void note_edge(input logic [PORT_W-1:0] p, input logic lvl,
				input logic dn, input logic [TIME_W-1:0] t);
			pulse_result_t r;
			logic [TIME_W-1:0] w;
			bit changed;
			if (int'(p) >= NUM_PORTS)
				return;
			if (lvl == LEVEL_HIGH) begin
				start_time[p] = t;
				armed[p] = 1'b1;
				return;
			end
			if (!armed[p])
				return;
			armed[p] = 1'b0;
			w = t - start_time[p];
			changed = 1'b0;
			if (w > TIME_W'(min_pulse)) begin
				if (dn == DIR_UP) begin
					if (tally[p] != COUNT_MAX) begin
						tally[p] = tally[p] + CNT_W'(1);
						changed = 1'b1;
					end
				end else begin
					if (tally[p] != '0) begin
						tally[p] = tally[p] - CNT_W'(1);
						changed = 1'b1;
					end
				end
			end
			r.port = p;
			r.width = w;
			r.counted = changed;
			r.count = tally[p];
			pending_pulses.push_back(r);
		endfunction

		function void compare_field(input string name, input logic [31:0] exp_v,
				input logic [31:0] act_v);
			if (act_v !== exp_v) begin
				$display("%0t ns: %s mismatch, expected 0x%08h, got 0x%08h",
					$time, name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_pulse(input logic [PORT_W-1:0] p,
				input logic [TIME_W-1:0] w, input logic c, input logic [CNT_W-1:0] n);
			pulse_result_t e;
			if (pending_pulses.size() == 0) begin
				$display("%0t ns: unexpected result beat, expected none, got port %0d width %0d",
					$time, p, w);
				errors++;
				return;
			end
			e = pending_pulses.pop_front();
			compare_field("out_port", 32'(e.port), 32'(p));
			compare_field("pulse_width_ms", e.width, w);
			compare_field("counted", 32'(e.counted), 32'(c));
			compare_field("count_value", e.count, n);
		endfunction

		function int pending();
			return pending_pulses.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [MIN_W-1:0]    cfg_wr_data;
	logic                in_valid;
	logic                in_ready;
	logic [PORT_W-1:0]   port_index;
	logic                pulse_level;
	logic                direction_level;
	logic [TIME_W-1:0]   time_ms;
	logic                out_valid;
	logic                out_ready;
	logic [PORT_W-1:0]   out_port;
	logic [TIME_W-1:0]   pulse_width_ms;
	logic                counted;
	logic [CNT_W-1:0]    count_value;

	// when set, neither side idles
	logic                calm;
	int                  cycle_count;

	pulse_tally tally_check = new();

	qualified_pulse_up_down_counter_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.port_index      (port_index),
		.pulse_level     (pulse_level),
		.direction_level (direction_level),
		.time_ms         (time_ms),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_port        (out_port),
		.pulse_width_ms  (pulse_width_ms),
		.counted         (counted),
		.count_value     (count_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: fails the run if it has not finished within LIMIT_CYCLES.
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("qualified_pulse_up_down_counter_unit test failed");
		$finish;
	end

	// Result side backpressure: stalls about 15 percent of the time, none
	// while the calm stretch runs.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	// Beat monitor. Everything is sampled at the edge, before the edge's
	// nonblocking updates land, so drivers and DUT never race with it.
	// Input beats feed the tally; output beats are checked in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				tally_check.note_edge(port_index, pulse_level, direction_level, time_ms);
			if (out_valid && out_ready)
				tally_check.check_pulse(out_port, pulse_width_ms, counted, count_value);
		end
	end

	// Drive one edge event. Called at a clock edge; returns at the edge that
	// accepts the beat. Valid stays up across back-to-back beats so a single
	// nonblocking write per signal happens in any time step.
	task automatic send_edge(input logic [PORT_W-1:0] p, input logic lvl,
			input logic dn, input logic [TIME_W-1:0] t);
		int gap;
		gap = 0;
		if (!calm)
			while ($urandom_range(0, 99) < IDLE_PERCENT)
				gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		port_index      <= p;
		pulse_level     <= lvl;
		direction_level <= dn;
		time_ms         <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Let every expected beat drain, then cover events still in flight that
	// produce nothing (high edges, low edges on unarmed ports).
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tally_check.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Threshold write; only called with the pipeline empty.
	task automatic write_min(input logic [MIN_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		tally_check.set_min(v);
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Pick a pulse width, weighted toward the threshold boundary.
	function automatic logic [TIME_W-1:0] pick_width(input logic [MIN_W-1:0] m);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 3)
			return TIME_W'(m) + TIME_W'($urandom_range(0, 4)) - 32'd2;
		else if (sel < 6)
			return TIME_W'($urandom_range(0, 2 * int'(m) + 10));
		else if (sel == 6)
			return $urandom;
		else if (sel == 7)
			return '0;
		else
			return TIME_W'(m) + 32'd1 + TIME_W'($urandom_range(0, 1000));
	endfunction

	// One random event: mostly arm-then-release pairs, some noise.
	task automatic send_random_edge();
		logic [PORT_W-1:0] p;
		logic dn;
		p = PORT_W'($urandom_range(0, NUM_PORTS - 1));
		dn = ($urandom_range(0, 99) < 60) ? DIR_UP : DIR_DOWN;
		if ($urandom_range(0, 99) < 80) begin
			if (tally_check.armed[p])
				send_edge(p, LEVEL_LOW, dn,
					tally_check.start_time[p] + pick_width(tally_check.min_pulse));
			else
				send_edge(p, LEVEL_HIGH, dn, $urandom);
		end else begin
			send_edge(p, 1'($urandom_range(0, 1)), dn, $urandom);
		end
	endtask

	initial begin
		logic [MIN_W-1:0] phase_min [NUM_PHASES];

		arst_n          <= 1'b0;
		calm            <= 1'b0;
		cfg_wr_en       <= 1'b0;
		cfg_wr_data     <= '0;
		in_valid        <= 1'b0;
		port_index      <= '0;
		pulse_level     <= LEVEL_LOW;
		direction_level <= DIR_UP;
		time_ms         <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset threshold of 200 ms.
		send_edge(1'b0, LEVEL_LOW,  DIR_UP,   32'd0);         // unarmed low, ignored
		send_edge(1'b0, LEVEL_HIGH, DIR_UP,   32'd100);
		send_edge(1'b0, LEVEL_LOW,  DIR_UP,   32'd300);       // exactly at min, no count
		send_edge(1'b0, LEVEL_HIGH, DIR_UP,   32'd1000);
		send_edge(1'b0, LEVEL_LOW,  DIR_UP,   32'd1201);      // one over min, counts up
		send_edge(1'b1, LEVEL_HIGH, DIR_DOWN, 32'd5);
		send_edge(1'b1, LEVEL_LOW,  DIR_DOWN, 32'd5);         // equal stamps, zero width
		send_edge(1'b1, LEVEL_HIGH, DIR_DOWN, 32'd0);
		send_edge(1'b1, LEVEL_LOW,  DIR_DOWN, 32'd1000);      // down at zero, blocked
		send_edge(1'b0, LEVEL_HIGH, DIR_UP,   32'd50);
		send_edge(1'b0, LEVEL_HIGH, DIR_UP,   32'd60);        // re-arm restarts timing
		send_edge(1'b0, LEVEL_LOW,  DIR_UP,   32'd400);
		send_edge(1'b1, LEVEL_HIGH, DIR_UP,   32'hFFFF_FF00);
		send_edge(1'b1, LEVEL_LOW,  DIR_UP,   32'h0000_0100); // timestamp wrap
		send_edge(1'b0, LEVEL_HIGH, DIR_DOWN, 32'h0000_0000);
		send_edge(1'b0, LEVEL_LOW,  DIR_DOWN, 32'hFFFF_FFFF); // widest pulse, counts down

		// Zero threshold: any nonzero width counts.
		wait_idle();
		write_min(16'd0);
		send_edge(1'b1, LEVEL_HIGH, DIR_UP, 32'd7);
		send_edge(1'b1, LEVEL_LOW,  DIR_UP, 32'd7);
		send_edge(1'b1, LEVEL_HIGH, DIR_UP, 32'd7);
		send_edge(1'b1, LEVEL_LOW,  DIR_UP, 32'd8);

		// Largest threshold, both sides of the boundary.
		wait_idle();
		write_min(16'hFFFF);
		send_edge(1'b0, LEVEL_HIGH, DIR_UP, 32'h8000_0000);
		send_edge(1'b0, LEVEL_LOW,  DIR_UP, 32'h8000_FFFF);
		send_edge(1'b0, LEVEL_HIGH, DIR_UP, 32'h8000_0000);
		send_edge(1'b0, LEVEL_LOW,  DIR_UP, 32'h8001_0000);

		// Random phases, each at its own threshold.
		phase_min[0] = 16'hFFFF;
		phase_min[1] = 16'd0;
		phase_min[2] = MIN_W'($urandom);
		phase_min[3] = 16'd1;
		phase_min[4] = MIN_PULSE_RESET;
		phase_min[5] = MIN_W'($urandom_range(0, 1000));
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			write_min(phase_min[ph]);
			for (int i = 0; i < PHASE_BEATS; i++) begin
				// one long stretch in the middle with no idling on either side
				calm <= (ph == 2) && (i >= 50) && (i < 250);
				send_random_edge();
			end
		end
		calm <= 1'b0;

		// Drain and finish.
		wait_idle();
		if (tally_check.pending() != 0) begin
			$display("%0t ns: results missing, expected %0d more beats, got 0",
				$time, tally_check.pending());
			tally_check.errors++;
		end
		if (tally_check.errors == 0)
			$display("qualified_pulse_up_down_counter_unit test passed");
		else
			$display("qualified_pulse_up_down_counter_unit test failed");
		$finish;
	end

endmodule
